// File: rtl/siocfg_pkg.sv
// Package for the Super I/O configuration unlock register file.
// Holds port and key constants, the setting-bank type and the settings decoder.
// No dependencies; used by the interfaces and the top level.
package siocfg_pkg;

    localparam int PORT_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 4;
    localparam int NUM_REGS = 15;

    // Unlock sequence ports and keys
    localparam logic [PORT_W-1:0] UNLOCK_PORT_A = 16'h02fa;
    localparam logic [PORT_W-1:0] UNLOCK_PORT_B = 16'h03fa;
    localparam logic [BYTE_W-1:0] KEY_FIRST     = 8'h55;
    localparam logic [BYTE_W-1:0] KEY_SECOND    = 8'haa;
    localparam logic [BYTE_W-1:0] KEY_THIRD     = 8'h36;
    localparam logic [BYTE_W-1:0] CHECK_SUM     = 8'hff;
    localparam logic [BYTE_W-1:0] IDLE_READ     = 8'hff;

    // Register indexes
    localparam int REG_CTRL       = 0;
    localparam int REG_COM_BASE   = 4;
    localparam int REG_LPT_BASE   = 6;
    localparam int REG_DEV_ENABLE = 12;
    localparam logic [INDEX_W-1:0] INDEX_BASE_EXIT = 4'd15;

    // Control bits
    localparam int CTRL_COM_EN_BIT = 2;
    localparam int CTRL_LPT_EN_BIT = 3;
    localparam int DEV_IDE_EN_BIT  = 7;
    localparam int DEV_FDC_EN_BIT  = 5;

    // Decoded I/O bases
    localparam logic [9:0] COM_FIRST_BASE  = 10'h3f8;
    localparam logic [9:0] COM_SECOND_BASE = 10'h2f8;
    localparam logic [9:0] LPT_BASE_378    = 10'h378;
    localparam logic [9:0] LPT_BASE_3BC    = 10'h3bc;
    localparam logic [9:0] LPT_BASE_278    = 10'h278;

    localparam logic [1:0] COM_NONE   = 2'd0;
    localparam logic [1:0] COM_FIRST  = 2'd1;
    localparam logic [1:0] COM_SECOND = 2'd2;

    localparam logic [2:0] IRQ_NONE = 3'd0;
    localparam logic [2:0] IRQ_7    = 3'd7;
    localparam logic [2:0] IRQ_5    = 3'd5;

    typedef logic [NUM_REGS-1:0][BYTE_W-1:0] setting_bank_t;

    // Entry 14 first, entry 0 last
    localparam setting_bank_t RESET_BYTES = {
        8'h00, 8'h00, 8'ha0, 8'h00, 8'h00, 8'hb0, 8'h00, 8'h00,
        8'h9e, 8'h00, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h0c
    };

    typedef struct packed {
        logic [1:0] com_select;
        logic       lpt_enable;
        logic [9:0] lpt_base;
        logic [2:0] lpt_irq;
        logic       ide_enable;
        logic       fdc_enable;
    } applied_t;

    function automatic applied_t decode_settings(input setting_bank_t bank);
        applied_t   res;
        logic [9:0] serial_io_base;
        logic [9:0] parallel_io_base;
        res              = '0;
        serial_io_base   = {bank[REG_COM_BASE], 2'b00};
        parallel_io_base = {bank[REG_LPT_BASE], 2'b00};
        if (bank[REG_CTRL][CTRL_COM_EN_BIT])
        begin
            if (serial_io_base == COM_FIRST_BASE)
                res.com_select = COM_FIRST;
            else if (serial_io_base == COM_SECOND_BASE)
                res.com_select = COM_SECOND;
            else
                res.com_select = COM_NONE;
        end
        if (bank[REG_CTRL][CTRL_LPT_EN_BIT])
        begin
            res.lpt_enable = 1'b1;
            res.lpt_base   = parallel_io_base;
            if (parallel_io_base == LPT_BASE_378 || parallel_io_base == LPT_BASE_3BC)
                res.lpt_irq = IRQ_7;
            else if (parallel_io_base == LPT_BASE_278)
                res.lpt_irq = IRQ_5;
            else
                res.lpt_irq = IRQ_NONE;
        end
        res.ide_enable = bank[REG_DEV_ENABLE][DEV_IDE_EN_BIT];
        res.fdc_enable = bank[REG_DEV_ENABLE][DEV_FDC_EN_BIT];
        return res;
    endfunction

endpackage

// File: rtl/siocfg_req_if.sv
// Request channel: one I/O access per transfer (read or write, port, data).
// Depends on siocfg_pkg for field widths.
interface siocfg_req_if;
    logic                               valid;
    logic                               ready;
    logic                               req_type;
    logic [siocfg_pkg::PORT_W-1:0]      bus_port;
    logic [siocfg_pkg::BYTE_W-1:0]      write_data;

    modport source (output valid, req_type, bus_port, write_data, input ready);
    modport sink   (input valid, req_type, bus_port, write_data, output ready);
endinterface

// File: rtl/siocfg_rsp_if.sv
// Response channel: read byte, unlock status and the applied device settings.
// Depends on siocfg_pkg for field widths.
interface siocfg_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [siocfg_pkg::BYTE_W-1:0]      read_data;
    logic                               config_active;
    logic [1:0]                         com_select;
    logic                               lpt_enable;
    logic [9:0]                         lpt_base;
    logic [2:0]                         lpt_irq;
    logic                               ide_enable;
    logic                               fdc_enable;

    modport source (output valid, read_data, config_active, com_select, lpt_enable,
                    lpt_base, lpt_irq, ide_enable, fdc_enable, input ready);
    modport sink   (input valid, read_data, config_active, com_select, lpt_enable,
                    lpt_base, lpt_irq, ide_enable, fdc_enable, output ready);
endinterface

// File: rtl/superio_config_unlock_regfile_unit.sv
// Top level of the Super I/O configuration unlock register file.
// Depends on siocfg_pkg, siocfg_req_if and siocfg_rsp_if.
//
// Each I/O access on req yields exactly one result on rsp, in order. An access
// is taken into an input register, then combinational logic updates the unlock
// sequence, index/data register file and applied settings and loads the result
// register, from which the result is shown on rsp; a busy rsp holds the access
// in the input register. One access per cycle is sustained while rsp takes
// results. A new request is taken while a finished result waits, as long as
// the input register is empty or can move on.
// The applied setting fields on rsp reflect the state after the access shown.
module superio_config_unlock_regfile_unit (
    input logic          clk,
    input logic          rst_n,
    siocfg_req_if.sink   req,
    siocfg_rsp_if.source rsp
);
    import siocfg_pkg::*;

    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_GOT_55,
        STEP_GOT_AA,
        STEP_GOT_36,
        STEP_GOT_BASE
    } step_t;

    // Input register
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_req_type_reg;
    logic [PORT_W-1:0]   s1_port_reg;
    logic [BYTE_W-1:0]   s1_data_reg;

    // Result register
    logic                rsp_valid_reg, rsp_valid_next;
    logic [BYTE_W-1:0]   read_data_reg, read_data_next;

    // Block state
    step_t               step_reg, step_next;
    logic                unlocked_reg, unlocked_next;
    logic [BYTE_W-1:0]   base_reg, base_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    setting_bank_t       bytes_reg, bytes_next;
    applied_t            applied_reg, applied_next;

    logic                advance;
    logic                handled;
    logic                step_adv;
    logic [BYTE_W-1:0]   check_sum;
    logic                hit_index;
    logic                hit_data;
    step_t               step_succ;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign check_sum = base_reg + s1_data_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req.valid && req.ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (advance)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_comb
    begin
        unique case (step_reg)
            STEP_IDLE:   step_succ = STEP_GOT_55;
            STEP_GOT_55: step_succ = STEP_GOT_AA;
            STEP_GOT_AA: step_succ = STEP_GOT_36;
            STEP_GOT_36: step_succ = STEP_GOT_BASE;
            default:     step_succ = STEP_IDLE;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        unlocked_next  = unlocked_reg;
        base_next      = base_reg;
        index_next     = index_reg;
        bytes_next     = bytes_reg;
        applied_next   = applied_reg;
        read_data_next = IDLE_READ;
        handled        = 1'b0;
        step_adv       = 1'b0;

        if (s1_req_type_reg)
        begin
            if (s1_port_reg == UNLOCK_PORT_A)
            begin
                handled = 1'b1;
                if (step_reg == STEP_IDLE && s1_data_reg == KEY_FIRST)
                    step_adv = 1'b1;
                else if (step_reg == STEP_GOT_BASE)
                    unlocked_next = (check_sum == CHECK_SUM);
            end
            else if (s1_port_reg == UNLOCK_PORT_B)
            begin
                handled = 1'b1;
                unique case (step_reg)
                    STEP_GOT_55: step_adv = (s1_data_reg == KEY_SECOND);
                    STEP_GOT_AA: step_adv = (s1_data_reg == KEY_THIRD);
                    STEP_GOT_36:
                    begin
                        base_next = s1_data_reg;
                        step_adv  = 1'b1;
                    end
                    default: step_adv = 1'b0;
                endcase
            end
        end

        // Index/data pair follows a base byte taken in this same access
        hit_index = (s1_port_reg == {6'b0, base_next, 2'b00});
        hit_data  = (s1_port_reg == {6'b0, base_next, 2'b01});

        if (!s1_req_type_reg)
        begin
            if (unlocked_reg && hit_index)
                read_data_next = {{(BYTE_W-INDEX_W){1'b0}}, index_reg};
            else if (unlocked_reg && hit_data)
                read_data_next = (index_reg == INDEX_BASE_EXIT) ? base_reg
                                                                : bytes_reg[index_reg];
        end
        else if (unlocked_next)
        begin
            if (hit_index)
            begin
                handled    = 1'b1;
                index_next = s1_data_reg[INDEX_W-1:0];
            end
            else if (hit_data)
            begin
                handled = 1'b1;
                if (index_reg == INDEX_BASE_EXIT)
                begin
                    unlocked_next = 1'b0;
                    applied_next  = decode_settings(bytes_reg);
                end
                else
                begin
                    bytes_next[index_reg] = s1_data_reg;
                end
            end
        end

        if (handled)
            step_next = step_adv ? step_succ : STEP_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            step_reg      <= STEP_IDLE;
            unlocked_reg  <= 1'b0;
            base_reg      <= '0;
            index_reg     <= '0;
            bytes_reg     <= RESET_BYTES;
            applied_reg   <= decode_settings(RESET_BYTES);
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                step_reg     <= step_next;
                unlocked_reg <= unlocked_next;
                base_reg     <= base_next;
                index_reg    <= index_next;
                bytes_reg    <= bytes_next;
                applied_reg  <= applied_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_req_type_reg <= req.req_type;
            s1_port_reg     <= req.bus_port;
            s1_data_reg     <= req.write_data;
        end
        if (advance)
            read_data_reg <= read_data_next;
    end

    // State only moves with a new result, so it always matches the result shown
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_data     = read_data_reg;
    assign rsp.config_active = unlocked_reg;
    assign rsp.com_select    = applied_reg.com_select;
    assign rsp.lpt_enable    = applied_reg.lpt_enable;
    assign rsp.lpt_base      = applied_reg.lpt_base;
    assign rsp.lpt_irq       = applied_reg.lpt_irq;
    assign rsp.ide_enable    = applied_reg.ide_enable;
    assign rsp.fdc_enable    = applied_reg.fdc_enable;

endmodule
